@@ hdl/tfn_pkg.sv @@
// shared widths and types for the triangle face normal pipeline
package tfn_pkg;

  // vertex coordinate width, signed Q8.8 at 16 bits
  localparam int COORD_BITS = 16;
  // edge magnitudes are brought into this many bits before the cross product
  localparam int EDGE_BITS  = 16;
  localparam int MAG_BITS   = (COORD_BITS > EDGE_BITS) ? COORD_BITS : EDGE_BITS;
  localparam int ESH_BITS   = $clog2(MAG_BITS + 1);
  // cross product terms and magnitudes
  localparam int PROD_BITS  = 2 * (EDGE_BITS + 1);
  localparam int CMAG_BITS  = PROD_BITS;
  localparam int LEAD_BITS  = $clog2(CMAG_BITS);
  // normalized cross magnitude lies in [2^29, 2^30)
  localparam int NORM_BITS  = 30;
  localparam int NORM_LEAD  = NORM_BITS - 1;
  localparam int HALF_BITS  = NORM_BITS / 2;
  // sum of squares and square root
  localparam int SUM_BITS   = 2 * NORM_BITS + 2;
  localparam int REM_BITS   = SUM_BITS + 1;
  localparam int ROOT_BITS  = NORM_BITS + 1;
  // division into Q1.14
  localparam int UNIT_SHIFT = 14;
  localparam int QUO_BITS   = UNIT_SHIFT + 1;
  localparam int DREM_BITS  = NORM_BITS + UNIT_SHIFT + 2;
  localparam int OUT_BITS   = 16;

  // normalized magnitudes with their signs, carried beside the root
  typedef struct packed {
    logic [2:0][NORM_BITS-1:0] nm;
    logic [2:0]                neg;
    logic                      degen;
  } tfn_side_t;

  // stage advance and request valid between pipeline sections
  typedef struct packed {
    logic adv;
    logic vld;
  } tfn_ctl_t;

endpackage

@@ hdl/triangle_face_normal.sv @@
// top level of the triangle face normal pipeline
//
// Takes one triangle per request on the in_ channel: nine signed Q8.8 vertex
// coordinates a, b, c. Returns one request on the out_ channel: the unit face
// normal of (b-a) x (c-a) as signed Q1.14 in nrm_x/y/z, or zeros with
// degenerate high when the cross product is zero.
// A request moves when valid is high and stall is low at a rising edge.
// From input request to output valid, a request passes the edge, cross product and
// normalization stages, the squares, the square root (one root bit per stage),
// the division (one quotient bit per stage) and the output register.
// Throughput is one triangle per cycle while out_stall does not hold the pipeline.
// All stages advance together; when the output holds a result and out_stall
// is high, the whole pipeline holds and in_stall is raised in the same cycle,
// so nothing is dropped or repeated.
// Synchronous active-low reset clears every stage valid bit; the pipeline is
// empty and ready right after reset.
module triangle_face_normal (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_a_x,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_a_y,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_a_z,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_b_x,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_b_y,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_b_z,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_c_x,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_c_y,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_c_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tfn_pkg::OUT_BITS-1:0] out_nrm_x,
  output logic signed [tfn_pkg::OUT_BITS-1:0] out_nrm_y,
  output logic signed [tfn_pkg::OUT_BITS-1:0] out_nrm_z,
  output logic                                out_degenerate
);
  import tfn_pkg::*;

  logic                         adv;
  tfn_ctl_t                     cross_ctl, sqrt_ctl, div_ctl;
  logic [8:0][COORD_BITS-1:0]   pts;
  logic                         cross_vld, sqrt_vld, div_vld;
  tfn_side_t                    cross_side, sqrt_side;
  logic [ROOT_BITS-1:0]         len;
  logic [2:0][QUO_BITS-1:0]     quo;
  logic [2:0]                   quo_neg;
  logic                         quo_degen;
  logic [2:0][OUT_BITS-1:0]     nrm_nxt;

  logic                         out_valid_r;
  logic [2:0][OUT_BITS-1:0]     nrm_r;
  logic                         degen_r;

  // whole pipeline moves unless a held result is stalled
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign pts = {in_c_z, in_c_y, in_c_x, in_b_z, in_b_y, in_b_x, in_a_z, in_a_y, in_a_x};

  assign cross_ctl = '{adv: adv, vld: in_valid};
  assign sqrt_ctl  = '{adv: adv, vld: cross_vld};
  assign div_ctl   = '{adv: adv, vld: sqrt_vld};

  tfn_cross u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (cross_ctl),
    .pts_i  (pts),
    .vld_o  (cross_vld),
    .side_o (cross_side)
  );

  tfn_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (sqrt_ctl),
    .side_i (cross_side),
    .vld_o  (sqrt_vld),
    .len_o  (len),
    .side_o (sqrt_side)
  );

  tfn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (div_ctl),
    .len_i   (len),
    .side_i  (sqrt_side),
    .vld_o   (div_vld),
    .quo_o   (quo),
    .neg_o   (quo_neg),
    .degen_o (quo_degen)
  );

  // apply signs, zero the normal of a degenerate triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (quo_degen) begin
        nrm_nxt[i] = '0;
      end else if (quo_neg[i]) begin
        nrm_nxt[i] = -OUT_BITS'(quo[i]);
      end else begin
        nrm_nxt[i] = OUT_BITS'(quo[i]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nrm_r   <= nrm_nxt;
      degen_r <= quo_degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_nrm_x      = nrm_r[0];
  assign out_nrm_y      = nrm_r[1];
  assign out_nrm_z      = nrm_r[2];
  assign out_degenerate = degen_r;

endmodule

@@ hdl/tfn_cross.sv @@
// edge vectors, cross product and normalization of its magnitude
module tfn_cross (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tfn_pkg::tfn_ctl_t                     ctl_i,
  input  logic [8:0][tfn_pkg::COORD_BITS-1:0]   pts_i,
  output logic                                  vld_o,
  output tfn_pkg::tfn_side_t                    side_o
);
  import tfn_pkg::*;

  localparam int CW = COORD_BITS;

  logic                        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [5:0][CW-1:0]          e1_mag_r;
  logic [5:0]                  e1_neg_r;
  logic signed [EDGE_BITS:0]   e2_r [6];
  logic signed [PROD_BITS-1:0] p3_r [6];
  logic [2:0][CMAG_BITS-1:0]   n4_mag_r;
  logic [2:0]                  n4_neg_r;
  logic                        d4_r;
  logic [2:0][CMAG_BITS-1:0]   n5_mag_r;
  logic [2:0]                  n5_neg_r;
  logic                        d5_r;
  logic [LEAD_BITS-1:0]        lead5_r;
  tfn_side_t                   side6_r;

  logic signed [CW:0]          dif [6];
  logic [5:0][CW-1:0]          dmag;
  logic [5:0]                  dneg;
  logic [MAG_BITS-1:0]         eor;
  logic [ESH_BITS-1:0]         esh;
  logic [MAG_BITS-1:0]         esc_wide [6];
  logic [EDGE_BITS-1:0]        esc [6];
  logic signed [EDGE_BITS:0]   e_nxt [6];
  logic signed [PROD_BITS:0]   cr [3];
  logic [2:0][CMAG_BITS-1:0]   cmag;
  logic [2:0]                  cneg;
  logic [CMAG_BITS-1:0]        cor;
  logic [LEAD_BITS-1:0]        lead;
  logic [CMAG_BITS+NORM_LEAD-1:0] nwide [3];
  tfn_side_t                   side_nxt;

  // edges b-a and c-a as sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i]     = $signed({pts_i[3+i][CW-1], pts_i[3+i]}) -
                   $signed({pts_i[i][CW-1], pts_i[i]});
      dif[3+i]   = $signed({pts_i[6+i][CW-1], pts_i[6+i]}) -
                   $signed({pts_i[i][CW-1], pts_i[i]});
    end
    for (int i = 0; i < 6; i++) begin
      dneg[i] = dif[i][CW];
      dmag[i] = dneg[i] ? CW'(-dif[i]) : CW'(dif[i]);
    end
  end

  // common right shift so every edge magnitude fits the edge width
  always_comb begin
    eor = '0;
    for (int i = 0; i < 6; i++) eor = eor | MAG_BITS'(e1_mag_r[i]);
    esh = '0;
    for (int k = 0; k < MAG_BITS; k++) begin
      if (k >= EDGE_BITS && eor[k]) esh = ESH_BITS'(k - EDGE_BITS + 1);
    end
    for (int i = 0; i < 6; i++) begin
      esc_wide[i] = MAG_BITS'(e1_mag_r[i]) >> esh;
      esc[i]      = esc_wide[i][EDGE_BITS-1:0];
      e_nxt[i]    = e1_neg_r[i] ? -$signed({1'b0, esc[i]}) : $signed({1'b0, esc[i]});
    end
  end

  // cross components as sign and magnitude, degenerate when all are zero
  always_comb begin
    cr[0] = (PROD_BITS+1)'(p3_r[0]) - (PROD_BITS+1)'(p3_r[1]);
    cr[1] = (PROD_BITS+1)'(p3_r[2]) - (PROD_BITS+1)'(p3_r[3]);
    cr[2] = (PROD_BITS+1)'(p3_r[4]) - (PROD_BITS+1)'(p3_r[5]);
    for (int i = 0; i < 3; i++) begin
      cneg[i] = cr[i][PROD_BITS];
      cmag[i] = cneg[i] ? CMAG_BITS'(-cr[i]) : CMAG_BITS'(cr[i]);
    end
  end

  // leading one of the largest magnitude
  always_comb begin
    cor  = n4_mag_r[0] | n4_mag_r[1] | n4_mag_r[2];
    lead = '0;
    for (int k = 0; k < CMAG_BITS; k++) begin
      if (cor[k]) lead = LEAD_BITS'(k);
    end
  end

  // shift so the leading one lands on the top normalized bit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nwide[i]          = {n5_mag_r[i], {NORM_LEAD{1'b0}}} >> lead5_r;
      side_nxt.nm[i]    = nwide[i][NORM_BITS-1:0];
    end
    side_nxt.neg   = n5_neg_r;
    side_nxt.degen = d5_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (ctl_i.adv) begin
      v1_r <= ctl_i.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      e1_mag_r <= dmag;
      e1_neg_r <= dneg;
      for (int i = 0; i < 6; i++) e2_r[i] <= e_nxt[i];
      p3_r[0]  <= PROD_BITS'(e2_r[1]) * PROD_BITS'(e2_r[5]);
      p3_r[1]  <= PROD_BITS'(e2_r[2]) * PROD_BITS'(e2_r[4]);
      p3_r[2]  <= PROD_BITS'(e2_r[2]) * PROD_BITS'(e2_r[3]);
      p3_r[3]  <= PROD_BITS'(e2_r[0]) * PROD_BITS'(e2_r[5]);
      p3_r[4]  <= PROD_BITS'(e2_r[0]) * PROD_BITS'(e2_r[4]);
      p3_r[5]  <= PROD_BITS'(e2_r[1]) * PROD_BITS'(e2_r[3]);
      n4_mag_r <= cmag;
      n4_neg_r <= cneg;
      d4_r     <= (cmag[0] == '0) && (cmag[1] == '0) && (cmag[2] == '0);
      n5_mag_r <= n4_mag_r;
      n5_neg_r <= n4_neg_r;
      d5_r     <= d4_r;
      lead5_r  <= lead;
      side6_r  <= side_nxt;
    end
  end

  assign vld_o  = v6_r;
  assign side_o = side6_r;

endmodule

@@ hdl/tfn_sqrt.sv @@
// sum of squares and one-bit-per-stage integer square root
module tfn_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tfn_pkg::tfn_ctl_t             ctl_i,
  input  tfn_pkg::tfn_side_t            side_i,
  output logic                          vld_o,
  output logic [tfn_pkg::ROOT_BITS-1:0] len_o,
  output tfn_pkg::tfn_side_t            side_o
);
  import tfn_pkg::*;

  logic                        va_r, vb_r;
  tfn_side_t                   sa_r, sb_r;
  logic [2*HALF_BITS-1:0]      hh_r [3];
  logic [2*HALF_BITS-1:0]      hl_r [3];
  logic [2*HALF_BITS-1:0]      ll_r [3];
  logic [SUM_BITS-1:0]         sum_r;
  logic [SUM_BITS-1:0]         sum_c;

  logic                        v_r    [ROOT_BITS+1];
  tfn_side_t                   s_r    [ROOT_BITS+1];
  logic [REM_BITS-1:0]         rem_r  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]        root_r [ROOT_BITS+1];

  // each square from three half-width products
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < 3; i++) begin
      sum_c = sum_c + (SUM_BITS'(hh_r[i]) << (2 * HALF_BITS))
                    + (SUM_BITS'(hl_r[i]) << (HALF_BITS + 1))
                    + SUM_BITS'(ll_r[i]);
    end
  end

  // product and sum stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (ctl_i.adv) begin
      va_r <= ctl_i.vld;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= (2*HALF_BITS)'(side_i.nm[i][NORM_BITS-1:HALF_BITS]) *
                   (2*HALF_BITS)'(side_i.nm[i][NORM_BITS-1:HALF_BITS]);
        hl_r[i] <= (2*HALF_BITS)'(side_i.nm[i][NORM_BITS-1:HALF_BITS]) *
                   (2*HALF_BITS)'(side_i.nm[i][HALF_BITS-1:0]);
        ll_r[i] <= (2*HALF_BITS)'(side_i.nm[i][HALF_BITS-1:0]) *
                   (2*HALF_BITS)'(side_i.nm[i][HALF_BITS-1:0]);
      end
      sa_r  <= side_i;
      sum_r <= sum_c;
      sb_r  <= sa_r;
    end
  end

  // root stage inputs
  assign v_r[0]    = vb_r;
  assign s_r[0]    = sb_r;
  assign rem_r[0]  = REM_BITS'(sum_r);
  assign root_r[0] = '0;

  // one root bit per stage, from the top bit down
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    localparam int B = ROOT_BITS - 1 - k;
    logic [REM_BITS-1:0] trial;
    logic                take;

    always_comb begin
      trial = (REM_BITS'(root_r[k]) << (B + 1)) + (REM_BITS'(1) << (2 * B));
      take  = rem_r[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (ctl_i.adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.adv) begin
        s_r[k+1]    <= s_r[k];
        rem_r[k+1]  <= take ? rem_r[k] - trial : rem_r[k];
        root_r[k+1] <= take ? root_r[k] | (ROOT_BITS'(1) << B) : root_r[k];
      end
    end
  end

  assign vld_o  = v_r[ROOT_BITS];
  assign len_o  = root_r[ROOT_BITS];
  assign side_o = s_r[ROOT_BITS];

endmodule

@@ hdl/tfn_div.sv @@
// rounded division of three magnitudes by the length, one quotient bit per stage
module tfn_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tfn_pkg::tfn_ctl_t                  ctl_i,
  input  logic [tfn_pkg::ROOT_BITS-1:0]      len_i,
  input  tfn_pkg::tfn_side_t                 side_i,
  output logic                               vld_o,
  output logic [2:0][tfn_pkg::QUO_BITS-1:0]  quo_o,
  output logic [2:0]                         neg_o,
  output logic                               degen_o
);
  import tfn_pkg::*;

  logic                          v_r   [QUO_BITS+1];
  logic [ROOT_BITS-1:0]          len_r [QUO_BITS+1];
  logic [2:0]                    neg_r [QUO_BITS+1];
  logic                          dg_r  [QUO_BITS+1];
  logic [2:0][DREM_BITS-1:0]     rem_r [QUO_BITS+1];
  logic [2:0][QUO_BITS-1:0]      q_r   [QUO_BITS+1];

  // dividend: magnitude in Q1.14 plus half the length for rounding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ctl_i.adv) begin
      v_r[0] <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      len_r[0] <= len_i;
      neg_r[0] <= side_i.neg;
      dg_r[0]  <= side_i.degen;
      q_r[0]   <= '0;
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= (DREM_BITS'(side_i.nm[i]) << UNIT_SHIFT) + DREM_BITS'(len_i >> 1);
      end
    end
  end

  // restoring division stages
  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    localparam int B = QUO_BITS - 1 - k;
    logic [DREM_BITS-1:0] dv;
    logic [2:0]           take;

    always_comb begin
      dv = DREM_BITS'(len_r[k]) << B;
      for (int i = 0; i < 3; i++) take[i] = rem_r[k][i] >= dv;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (ctl_i.adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.adv) begin
        len_r[k+1] <= len_r[k];
        neg_r[k+1] <= neg_r[k];
        dg_r[k+1]  <= dg_r[k];
        for (int i = 0; i < 3; i++) begin
          rem_r[k+1][i] <= take[i] ? rem_r[k][i] - dv : rem_r[k][i];
          q_r[k+1][i]   <= take[i] ? q_r[k][i] | (QUO_BITS'(1) << B) : q_r[k][i];
        end
      end
    end
  end

  assign vld_o   = v_r[QUO_BITS];
  assign quo_o   = q_r[QUO_BITS];
  assign neg_o   = neg_r[QUO_BITS];
  assign degen_o = dg_r[QUO_BITS];

endmodule

@@ test/triangle_face_normal_chk.sv @@
// checker for the triangle face normal pipeline: predicts each normal and compares
`timescale 1ns / 100ps
module triangle_face_normal_chk (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_a_x,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_a_y,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_a_z,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_b_x,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_b_y,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_b_z,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_c_x,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_c_y,
  input  logic signed [tfn_pkg::COORD_BITS-1:0] in_c_z,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [tfn_pkg::OUT_BITS-1:0]   out_nrm_x,
  input  logic signed [tfn_pkg::OUT_BITS-1:0]   out_nrm_y,
  input  logic signed [tfn_pkg::OUT_BITS-1:0]   out_nrm_z,
  input  logic                                  out_degenerate,
  output int                                    fail_count,
  output int                                    pending
);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        degen;
  } normal_t;

  normal_t normals_due[$];

  // integer square root, floor
  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit normal of (b-a) x (c-a) in Q1.14
  function automatic normal_t face_normal(input longint ax, ay, az, bx, by, bz, cx, cy, cz);
    longint ux, uy, uz, vx, vy, vz;
    longint n[3];
    longint unsigned m[3];
    longint unsigned mx, s, len, q;
    normal_t r;
    ux = bx - ax; uy = by - ay; uz = bz - az;
    vx = cx - ax; vy = cy - ay; vz = cz - az;
    // edges already fit 17 bits signed, no edge scaling at 16-bit coordinates
    n[0] = uy * vz - uz * vy;
    n[1] = uz * vx - ux * vz;
    n[2] = ux * vy - uy * vx;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (n[i] < 0) ? -n[i] : n[i];
      if (m[i] > mx) mx = m[i];
    end
    r = '0;
    if (mx == 0) begin
      r.degen = 1'b1;
      return r;
    end
    while (mx >= 64'd1 << 30) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < 64'd1 << 29) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + (len >> 1)) / len;
      if (n[i] < 0) q = -q;
      if (i == 0) r.x = q[15:0];
      else if (i == 1) r.y = q[15:0];
      else r.z = q[15:0];
    end
    return r;
  endfunction

  assign pending = normals_due.size();

  // predict on input requests, compare on output requests
  always @(posedge clk) begin
    normal_t got;
    normal_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        normals_due.push_back(face_normal(in_a_x, in_a_y, in_a_z, in_b_x, in_b_y,
                                          in_b_z, in_c_x, in_c_y, in_c_z));
      if (out_valid && !out_stall) begin
        got = {out_nrm_x, out_nrm_y, out_nrm_z, out_degenerate};
        if (normals_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = normals_due.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"normal mismatch: expected x=%0d y=%0d z=%0d deg=%0b,",
                        " got x=%0d y=%0d z=%0d deg=%0b"},
                       $signed(want.x), $signed(want.y), $signed(want.z), want.degen,
                       $signed(got.x), $signed(got.y), $signed(got.z), got.degen);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/triangle_face_normal_tb.sv @@
// testbench top for the triangle face normal pipeline: stimulus and verdict
`timescale 1ns / 100ps
module triangle_face_normal_tb;
  import tfn_pkg::*;

  localparam int LATENCY = 56;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [COORD_BITS-1:0] v[9];
  logic out_valid;
  logic out_stall;
  logic signed [OUT_BITS-1:0] nx, ny, nz;
  logic deg;
  int fail_count;
  int pending;
  bit hold_long;
  bit long_hold_done;

  triangle_face_normal dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(v[0]), .in_a_y(v[1]), .in_a_z(v[2]), .in_b_x(v[3]), .in_b_y(v[4]),
    .in_b_z(v[5]), .in_c_x(v[6]), .in_c_y(v[7]), .in_c_z(v[8]),
    .out_valid(out_valid), .out_stall(out_stall), .out_nrm_x(nx), .out_nrm_y(ny),
    .out_nrm_z(nz), .out_degenerate(deg)
  );

  triangle_face_normal_chk chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(v[0]), .in_a_y(v[1]), .in_a_z(v[2]), .in_b_x(v[3]), .in_b_y(v[4]),
    .in_b_z(v[5]), .in_c_x(v[6]), .in_c_y(v[7]), .in_c_z(v[8]),
    .out_valid(out_valid), .out_stall(out_stall), .out_nrm_x(nx), .out_nrm_y(ny),
    .out_nrm_z(nz), .out_degenerate(deg), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one request and wait until it is taken
  task automatic send_tri(input logic signed [COORD_BITS-1:0] t[9]);
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) v[i] <= t[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // random coordinate, sometimes near the extremes or small
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    unique case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 16))) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver stall pattern, with one long hold-off
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_done = 1'b1;
        wait (!hold_long);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= $urandom_range(0, 2) != 0;
      end
    end
  end

  initial begin
    logic signed [COORD_BITS-1:0] t[9];
    in_valid = 1'b0;
    for (int i = 0; i < 9; i++) v[i] = '0;
    hold_long = 1'b0;
    long_hold_done = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unit triangles, degenerate, extremes
    t = '{0, 0, 0, 256, 0, 0, 0, 256, 0}; send_tri(t);
    t = '{0, 0, 0, 0, 256, 0, 0, 0, 256}; send_tri(t);
    t = '{0, 0, 0, 0, 0, 256, 256, 0, 0}; send_tri(t);
    t = '{0, 0, 0, 0, 256, 0, 256, 0, 0}; send_tri(t);
    t = '{5, 5, 5, 5, 5, 5, 5, 5, 5}; send_tri(t);
    t = '{0, 0, 0, 1, 1, 1, 2, 2, 2}; send_tri(t);
    t = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
    send_tri(t);
    t = '{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768};
    send_tri(t);
    t = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767};
    send_tri(t);
    t = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_tri(t);
    t = '{0, 0, 0, 1, 2, 3, 3, 1, 2}; send_tri(t);
    t = '{-1, -1, -1, -1, -1, -1, 0, 0, 0}; send_tri(t);
    t = '{-21846, 21845, -1, 21845, -21846, 0, 1, 1, 21845}; send_tri(t);
    idle(1);

    // keep offering while the receiver holds off, so the pipeline fills
    hold_long = 1'b1;
    for (int k = 0; k < 80 && !long_hold_done; k++) begin
      for (int i = 0; i < 9; i++) t[i] = rand_coord();
      send_tri(t);
    end
    hold_long = 1'b0;

    // pause until every expected result has arrived
    idle(1);
    while (pending != 0) @(posedge clk);

    // random bursts with random gaps
    for (int k = 0; k < 400;) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst; j++, k++) begin
        for (int i = 0; i < 9; i++) t[i] = rand_coord();
        if ($urandom_range(0, 15) == 0) t[6] = t[3];
        send_tri(t);
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
